// ===== rtl/core/mtt_pkg.sv =====
// Shared constants and codes of the multi timer table.
`timescale 1ns / 1ps
package mtt_pkg;

  // Table size and per-tick expiry limit.
  localparam int unsigned MaxTimers  = 8;
  localparam int unsigned MaxResults = 8;
  localparam int unsigned IdxW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
  localparam int unsigned CntW = $clog2(MaxTimers + 1);
  localparam int unsigned ResW = $clog2(MaxResults + 1);

  // Field widths.
  localparam int unsigned FuncW    = 3;
  localparam int unsigned IdW      = 8;
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned BeatW    = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;

  // Command codes.
  localparam logic [FuncW-1:0] FUNC_START  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_DELETE = 3'd1;
  localparam logic [FuncW-1:0] FUNC_QUERY  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_TICK   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_SYNC   = 3'd4;
  localparam logic [FuncW-1:0] FUNC_HOLD   = 3'd5;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_START  = 2'd0;
  localparam logic [KindW-1:0] KIND_DELETE = 2'd1;
  localparam logic [KindW-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KindW-1:0] KIND_EXPIRY = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd2;

endpackage

// ===== rtl/core/mtt_if.sv =====
// Valid/ready channel interfaces for commands and results of the timer table.
`timescale 1ns / 1ps
interface mtt_in_if import mtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [IdW-1:0]      timer_id;
  logic [TimeoutW-1:0] timeout;
  logic                hold;

  modport source (output valid, func, timer_id, timeout, hold, input ready);
  modport sink   (input valid, func, timer_id, timeout, hold, output ready);
endinterface

interface mtt_out_if import mtt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [IdW-1:0]     out_id;
  logic [BeatW-1:0]   beats;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, kind, out_id, beats, status, last, input ready);
  modport sink   (input valid, kind, out_id, beats, status, last, output ready);
endinterface

// ===== rtl/core/multi_timer_table.sv =====
// Top level of the multi timer table: a sorted table of timers on a shared beat counter.
`timescale 1ns / 1ps
// The block keeps up to MaxTimers timers, each with an 8-bit id, its start beat and
// its deadline, packed in the low slots and sorted by ascending deadline (equal
// deadlines in start order). Commands arrive on in_i and results leave on out_o,
// both valid/ready channels; a command is taken on a transfer and the block then
// works on it alone, so in_i.ready is low until its last result sits in the output
// register. Start, delete and query give one result each; a tick outside hold gives one expiry
// result per timer whose deadline is reached (at most MaxResults per tick, the last
// flagged), and sync, set hold and ticks without expiry give none. All beat and deadline
// arithmetic goes through one 32-bit adder/subtractor under a small sequencer; ids are
// matched one slot per cycle. A start does an id scan, an optional removal and the
// deadline add, then an insertion walk that moves one slot per cycle; delete and query
// scan for the id. With eight timers a tick that expires eight timers is the longest
// command. The beat counter returns to zero whenever the table becomes empty.
module multi_timer_table import mtt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  mtt_in_if.sink    in_i,
  mtt_out_if.source out_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIND     = 4'd1;
  localparam logic [3:0] S_REMOVE   = 4'd2;
  localparam logic [3:0] S_STARTCHK = 4'd3;
  localparam logic [3:0] S_INSERT   = 4'd4;
  localparam logic [3:0] S_QUERY    = 4'd5;
  localparam logic [3:0] S_TICKINC  = 4'd6;
  localparam logic [3:0] S_EXPCHK   = 4'd7;
  localparam logic [3:0] S_EXPELAP  = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0] state_q;
  logic [3:0] ret_q;

  // Latched command.
  logic [FuncW-1:0]    func_q;
  logic [IdW-1:0]      id_q;
  logic [TimeoutW-1:0] timeout_q;

  // Block state.
  logic             hold_q;
  logic [BeatW-1:0] beat_q;
  logic [CntW-1:0]  cnt_q;

  // Sequencer working registers.
  logic [CntW-1:0]  idx_q;
  logic [IdxW-1:0]  pos_q;
  logic [ResW-1:0]  k_q;
  logic [BeatW-1:0] dl_q;
  logic             pend_q;

  // Staged result, copied into the output register when it is free.
  logic [KindW-1:0]   res_kind_q;
  logic [IdW-1:0]     res_id_q;
  logic [BeatW-1:0]   res_beats_q;
  logic [StatusW-1:0] res_status_q;
  logic               res_last_q;

  // Timer table; only slots below cnt_q hold live timers.
  logic [IdW-1:0]   ent_id_q    [MaxTimers];
  logic [BeatW-1:0] ent_start_q [MaxTimers];
  logic [BeatW-1:0] ent_dl_q    [MaxTimers];

  // Output register.
  logic               out_valid_q;
  logic [KindW-1:0]   out_kind_q;
  logic [IdW-1:0]     out_id_q;
  logic [BeatW-1:0]   out_beats_q;
  logic [StatusW-1:0] out_status_q;
  logic               out_last_q;

  // Shared arithmetic unit: a + b or a - b, with carry out (a >= b when subtracting).
  logic [BeatW-1:0] alu_a;
  logic [BeatW-1:0] alu_b;
  logic             alu_sub;
  logic [BeatW:0]   alu_sum;
  logic             alu_carry;
  logic [BeatW-1:0] alu_res;

  logic [IdxW-1:0]  rd_idx;
  logic [IdxW-1:0]  wr_idx;
  logic [BeatW-1:0] rd_dl;
  logic             out_free;
  logic             in_xfer;
  logic             id_hit;
  logic             exp_hit;
  logic             ins_here;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;

  assign wr_idx = idx_q[IdxW-1:0];
  assign rd_dl  = ent_dl_q[rd_idx];
  assign id_hit = (ent_id_q[idx_q[IdxW-1:0]] == id_q);

  always_comb begin
    rd_idx = '0;
    if (state_q == S_INSERT) begin
      rd_idx = IdxW'(idx_q - 1'b1);
    end else if (state_q == S_QUERY) begin
      rd_idx = idx_q[IdxW-1:0];
    end
  end

  always_comb begin
    alu_a   = beat_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_STARTCHK: begin
        alu_b = BeatW'(timeout_q);
      end
      S_INSERT: begin
        alu_a   = dl_q;
        alu_b   = rd_dl;
        alu_sub = 1'b1;
      end
      S_QUERY: begin
        alu_a   = rd_dl;
        alu_b   = beat_q;
        alu_sub = 1'b1;
      end
      S_TICKINC: begin
        alu_b = BeatW'(1);
      end
      S_EXPCHK: begin
        alu_b   = rd_dl;
        alu_sub = 1'b1;
      end
      S_EXPELAP: begin
        alu_b   = ent_start_q[0];
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {BeatW{alu_sub}}} + {{BeatW{1'b0}}, alu_sub};
  assign alu_carry = alu_sum[BeatW];
  assign alu_res   = alu_sum[BeatW-1:0];

  // The earliest deadline is due when beat >= deadline, within the per-tick limit.
  assign exp_hit  = (cnt_q != '0) && (k_q < ResW'(MaxResults)) && alu_carry;
  // The new timer goes at idx_q once the slot below holds a deadline not above it.
  assign ins_here = (idx_q == '0) || alu_carry;

  // Output valid: set when a staged result moves into the output register, cleared
  // when the held result is taken and nothing replaces it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Control and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      func_q       <= FUNC_START;
      id_q         <= '0;
      timeout_q    <= '0;
      hold_q       <= 1'b0;
      beat_q       <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      k_q          <= '0;
      dl_q         <= '0;
      pend_q       <= 1'b0;
      res_kind_q   <= KIND_START;
      res_id_q     <= '0;
      res_beats_q  <= '0;
      res_status_q <= STATUS_OK;
      res_last_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            func_q    <= in_i.func;
            id_q      <= in_i.timer_id;
            timeout_q <= in_i.timeout;
            idx_q     <= '0;
            ret_q     <= S_IDLE;
            case (in_i.func) inside
              FUNC_START, FUNC_DELETE, FUNC_QUERY: begin
                state_q <= S_FIND;
              end
              FUNC_TICK: begin
                if (cnt_q != '0) begin
                  state_q <= S_TICKINC;
                end
              end
              FUNC_SYNC: begin
                state_q <= S_TICKINC;
              end
              FUNC_HOLD: begin
                hold_q <= in_i.hold;
              end
              default: begin
              end
            endcase
          end
        end
        S_FIND: begin
          res_id_q    <= id_q;
          res_beats_q <= '0;
          res_last_q  <= 1'b1;
          if (idx_q == cnt_q) begin
            // Id not in the table.
            if (func_q == FUNC_START) begin
              state_q <= S_STARTCHK;
            end else begin
              res_kind_q   <= (func_q == FUNC_DELETE) ? KIND_DELETE : KIND_QUERY;
              res_status_q <= STATUS_NOT_FOUND;
              state_q      <= S_EMIT;
            end
          end else if (id_hit) begin
            pos_q   <= idx_q[IdxW-1:0];
            state_q <= (func_q == FUNC_QUERY) ? S_QUERY : S_REMOVE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_REMOVE: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            beat_q <= '0;
          end
          if (func_q == FUNC_START) begin
            state_q <= S_STARTCHK;
          end else if (func_q == FUNC_DELETE) begin
            res_kind_q   <= KIND_DELETE;
            res_status_q <= STATUS_OK;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_EXPCHK;
          end
        end
        S_STARTCHK: begin
          res_kind_q <= KIND_START;
          if (cnt_q == CntW'(MaxTimers)) begin
            res_status_q <= STATUS_FULL;
            state_q      <= S_EMIT;
          end else begin
            dl_q    <= alu_res;
            idx_q   <= cnt_q;
            state_q <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (ins_here) begin
            cnt_q        <= cnt_q + 1'b1;
            res_status_q <= STATUS_OK;
            state_q      <= S_EMIT;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        S_QUERY: begin
          // A deadline already passed answers zero remaining beats.
          res_kind_q   <= KIND_QUERY;
          res_status_q <= STATUS_OK;
          res_beats_q  <= alu_res[BeatW-1] ? '0 : alu_res;
          state_q      <= S_EMIT;
        end
        S_TICKINC: begin
          beat_q <= alu_res;
          k_q    <= '0;
          if ((func_q == FUNC_SYNC) || hold_q) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_EXPCHK;
          end
        end
        S_EXPCHK: begin
          // A staged expiry is released only once it is known whether another follows.
          if (exp_hit) begin
            if (pend_q) begin
              pend_q     <= 1'b0;
              res_last_q <= 1'b0;
              ret_q      <= S_EXPCHK;
              state_q    <= S_EMIT;
            end else begin
              state_q <= S_EXPELAP;
            end
          end else if (pend_q) begin
            pend_q     <= 1'b0;
            res_last_q <= 1'b1;
            ret_q      <= S_IDLE;
            state_q    <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EXPELAP: begin
          res_kind_q   <= KIND_EXPIRY;
          res_id_q     <= ent_id_q[0];
          res_beats_q  <= alu_res;
          res_status_q <= STATUS_OK;
          pend_q       <= 1'b1;
          k_q          <= k_q + 1'b1;
          pos_q        <= '0;
          state_q      <= S_REMOVE;
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= ret_q;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Table storage and output payload, without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_REMOVE) begin
      for (int i = 0; i < int'(MaxTimers) - 1; i++) begin
        if (IdxW'(i) >= pos_q) begin
          ent_id_q[i]    <= ent_id_q[i+1];
          ent_start_q[i] <= ent_start_q[i+1];
          ent_dl_q[i]    <= ent_dl_q[i+1];
        end
      end
    end
    if (state_q == S_INSERT) begin
      if (ins_here) begin
        ent_id_q[wr_idx]    <= id_q;
        ent_start_q[wr_idx] <= beat_q;
        ent_dl_q[wr_idx]    <= dl_q;
      end else begin
        ent_id_q[wr_idx]    <= ent_id_q[rd_idx];
        ent_start_q[wr_idx] <= ent_start_q[rd_idx];
        ent_dl_q[wr_idx]    <= rd_dl;
      end
    end
    if ((state_q == S_EMIT) && out_free) begin
      out_kind_q   <= res_kind_q;
      out_id_q     <= res_id_q;
      out_beats_q  <= res_beats_q;
      out_status_q <= res_status_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.kind   = out_kind_q;
  assign out_o.out_id = out_id_q;
  assign out_o.beats  = out_beats_q;
  assign out_o.status = out_status_q;
  assign out_o.last   = out_last_q;

endmodule

// ===== rtl/core/mtt_checker.sv =====
// Port-level assertions for the multi timer table and their bind to the top level.
`timescale 1ns / 1ps
module mtt_checker import mtt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [FuncW-1:0]   in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KindW-1:0]   out_kind_i,
  input logic [IdW-1:0]     out_id_i,
  input logic [BeatW-1:0]   out_beats_i,
  input logic [StatusW-1:0] out_status_i,
  input logic               out_last_i
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_id_i)
      && $stable(out_beats_i) && $stable(out_status_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Start, delete, query and sync commands keep the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FUNC_START || in_func_i == FUNC_DELETE
      || in_func_i == FUNC_QUERY || in_func_i == FUNC_SYNC) |=> !in_ready_i)
    else $error("block ready right after a multi-cycle command");

  // Expiries never report an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_EXPIRY |-> out_status_i == STATUS_OK)
    else $error("expiry with error status");

  // A full table is reported only on a start acknowledge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STATUS_FULL |-> out_kind_i == KIND_START)
    else $error("table full on a result other than start");

  // Start and delete acknowledges are single results with zero beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_START || out_kind_i == KIND_DELETE)
      |-> out_beats_i == '0 && out_last_i)
    else $error("bad start or delete acknowledge");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.kind),
  .out_id_i     (out_o.out_id),
  .out_beats_i  (out_o.beats),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

// ===== tb/tb.sv =====
// Self-checking testbench of the multi timer table: directed and random commands.
`timescale 1ns / 1ps
module tb;
  import mtt_pkg::*;

  // One command as it travels on the input channel.
  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [IdW-1:0]      timer_id;
    logic [TimeoutW-1:0] timeout;
    logic                hold;
  } cmd_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [IdW-1:0]     out_id;
    logic [BeatW-1:0]   beats;
    logic [StatusW-1:0] status;
    logic               last;
  } res_t;

  // Codes the block must ignore.
  localparam logic [FuncW-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [FuncW-1:0] FUNC_UNUSED_HI = 3'd7;

  localparam int RandomCmds    = 350;
  localparam int QuietTail     = 40;    // No idling once this few commands are left.
  localparam int HoldOffAfter  = 80;    // Commands sent before the long output stall.
  localparam int HoldOffCycles = 200;
  localparam int DrainCycles   = 40;    // Settling time once every result has arrived.
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 60;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // The channel inputs of the block come from these registers, so that every one
  // of them holds a known value from the very start of the run.
  logic drv_valid = 1'b0;
  cmd_t drv_cmd   = '0;
  logic rdy_q     = 1'b0;

  mtt_in_if  in_if ();
  mtt_out_if out_if ();

  assign in_if.valid    = drv_valid;
  assign in_if.func     = drv_cmd.func;
  assign in_if.timer_id = drv_cmd.timer_id;
  assign in_if.timeout  = drv_cmd.timeout;
  assign in_if.hold     = drv_cmd.hold;
  assign out_if.ready   = rdy_q;

  multi_timer_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   cmds_sent = 0;
  int   errors    = 0;

  // Our own copy of the timer table. Entries stay packed at the low slots and
  // sorted by ascending deadline, ties kept in start order.
  logic [BeatW-1:0] tt_count;
  int               tt_used;
  logic [IdW-1:0]   tt_id       [MaxTimers];
  logic [BeatW-1:0] tt_start    [MaxTimers];
  logic [BeatW-1:0] tt_deadline [MaxTimers];
  logic             tt_hold;
  logic             tt_running;

  initial begin
    tt_count   = '0;
    tt_used    = 0;
    tt_hold    = 1'b0;
    tt_running = 1'b0;
  end

  function automatic int tt_find(logic [IdW-1:0] id);
    for (int i = 0; i < tt_used; i++) begin
      if (tt_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Removing the last entry stops the table and returns the counter to zero.
  function automatic void tt_remove(int pos);
    for (int i = pos; i + 1 < tt_used; i++) begin
      tt_id[i]       = tt_id[i + 1];
      tt_start[i]    = tt_start[i + 1];
      tt_deadline[i] = tt_deadline[i + 1];
    end
    tt_used--;
    if (tt_used == 0) begin
      tt_count   = '0;
      tt_running = 1'b0;
    end
  endfunction

  function automatic void push_result(logic [KindW-1:0] kind, logic [IdW-1:0] id,
                                      logic [BeatW-1:0] beats,
                                      logic [StatusW-1:0] status, logic last);
    res_t r;
    r.kind   = kind;
    r.out_id = id;
    r.beats  = beats;
    r.status = status;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted command to the table copy and queues the results it
  // must cause, in order.
  function automatic void timer_table_apply(cmd_t c);
    int               pos;
    int               i;
    int               k;
    logic [BeatW-1:0] dl;
    logic [BeatW-1:0] diff;
    pos = tt_find(c.timer_id);
    case (c.func)
      FUNC_START: begin
        // A restart drops the old entry first, which may empty the table and so
        // reset the counter before the new deadline is formed.
        if (pos >= 0) tt_remove(pos);
        if (tt_used >= MaxTimers) begin
          push_result(KIND_START, c.timer_id, '0, STATUS_FULL, 1'b1);
        end else begin
          dl = tt_count + BeatW'(c.timeout);
          i  = tt_used;
          while (i > 0 && tt_deadline[i - 1] > dl) begin
            tt_id[i]       = tt_id[i - 1];
            tt_start[i]    = tt_start[i - 1];
            tt_deadline[i] = tt_deadline[i - 1];
            i--;
          end
          tt_id[i]       = c.timer_id;
          tt_start[i]    = tt_count;
          tt_deadline[i] = dl;
          tt_used++;
          tt_running = 1'b1;
          push_result(KIND_START, c.timer_id, '0, STATUS_OK, 1'b1);
        end
      end
      FUNC_DELETE: begin
        if (pos >= 0) begin
          tt_remove(pos);
          push_result(KIND_DELETE, c.timer_id, '0, STATUS_OK, 1'b1);
        end else begin
          push_result(KIND_DELETE, c.timer_id, '0, STATUS_NOT_FOUND, 1'b1);
        end
      end
      FUNC_QUERY: begin
        if (pos >= 0) begin
          // Past the deadline the signed difference goes negative and reads as zero.
          diff = tt_deadline[pos] - tt_count;
          if (diff[BeatW-1]) diff = '0;
          push_result(KIND_QUERY, c.timer_id, diff, STATUS_OK, 1'b1);
        end else begin
          push_result(KIND_QUERY, c.timer_id, '0, STATUS_NOT_FOUND, 1'b1);
        end
      end
      FUNC_TICK: begin
        if (tt_running) begin
          tt_count++;
          if (!tt_hold) begin
            k = 0;
            while (k < MaxResults && tt_used > 0 && tt_deadline[0] <= tt_count) begin
              push_result(KIND_EXPIRY, tt_id[0], tt_count - tt_start[0], STATUS_OK, 1'b0);
              k++;
              tt_remove(0);
            end
            if (k > 0) expected_results[expected_results.size() - 1].last = 1'b1;
          end
        end
      end
      FUNC_SYNC: tt_count++;
      FUNC_HOLD: tt_hold = c.hold;
      default: ;
    endcase
  endfunction

  function automatic cmd_t mk_cmd(logic [FuncW-1:0] func, logic [IdW-1:0] id,
                                  logic [TimeoutW-1:0] timeout, logic hold);
    cmd_t c;
    c.func     = func;
    c.timer_id = id;
    c.timeout  = timeout;
    c.hold     = hold;
    return c;
  endfunction

  // Clock and the single reset at the start of the run.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  int idle_left = 0;

  // Command driver. The current command stays on the channel until it is taken;
  // on each transfer the predictor is updated, then the next command follows at
  // once or after a short idle burst.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    cmd_t nxt;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_cmd   <= '0;
      idle_left <= 0;
    end else if (!drv_valid || in_if.ready) begin
      if (drv_valid) begin
        timer_table_apply(drv_cmd);
        cmds_sent <= cmds_sent + 1;
      end
      if (idle_left > 0) begin
        drv_valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (drv_valid && pending_cmds.size() > QuietTail &&
                   $urandom_range(0, 3) == 0) begin
        // Idle burst, starting with this cycle.
        drv_valid <= 1'b0;
        idle_left <= $urandom_range(0, 3);
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        drv_cmd   <= nxt;
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result ready generation. Short random stalls, plus one long hold-off while
  // the driver keeps offering commands, so the block backs up onto its input.
  int   stall_left    = 0;
  int   hold_off_left = 0;
  logic hold_off_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    if (!rst_ni) begin
      rdy_q         <= 1'b0;
      stall_left    <= 0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
    end else if (hold_off_left > 0) begin
      rdy_q         <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (!hold_off_done && cmds_sent >= HoldOffAfter) begin
      rdy_q         <= 1'b0;
      hold_off_left <= HoldOffCycles - 1;
      hold_off_done <= 1'b1;
    end else if (stall_left > 0) begin
      rdy_q      <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pending_cmds.size() > QuietTail && $urandom_range(0, 4) == 0) begin
      rdy_q      <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      rdy_q <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [BeatW-1:0] want, logic [BeatW-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Result monitor: every transfer on the output is matched against the oldest
  // expected result, field by field.
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result with none expected, expected none, actual kind %0d id %0d",
                   $time, out_if.kind, out_if.out_id);
        end
      end else begin
        want = expected_results.pop_front();
        check_field("kind",   BeatW'(want.kind),   BeatW'(out_if.kind));
        check_field("out_id", BeatW'(want.out_id), BeatW'(out_if.out_id));
        check_field("beats",  want.beats,          out_if.beats);
        check_field("status", BeatW'(want.status), BeatW'(out_if.status));
        check_field("last",   BeatW'(want.last),   BeatW'(out_if.last));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int   useful;
    int   r;
    cmd_t c;

    // Directed part. A tick on an empty table does nothing, while a sync still
    // moves the counter.
    pending_cmds.push_back(mk_cmd(FUNC_TICK,   8'd0,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_SYNC,   8'd0,   20'd0, 1'b0));
    // Delete and query of ids that are absent.
    pending_cmds.push_back(mk_cmd(FUNC_DELETE, 8'd255, 20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_QUERY,  8'd128, 20'd0, 1'b0));
    // Zero timeout expires on the next tick, which empties the table.
    pending_cmds.push_back(mk_cmd(FUNC_START,  8'd0,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_TICK,   8'd0,   20'd0, 1'b0));
    // A restart of the only timer empties the table and resets the counter first.
    pending_cmds.push_back(mk_cmd(FUNC_START,  8'd5,   20'd3, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_SYNC,   8'd0,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_START,  8'd5,   20'd2, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_QUERY,  8'd5,   20'd0, 1'b0));
    // Fill the table, seven new timers with equal deadlines, then try one more start.
    pending_cmds.push_back(mk_cmd(FUNC_START,  8'd255, 20'd1, 1'b0));
    for (int i = 1; i <= 7; i++) begin
      if (i != 5) pending_cmds.push_back(mk_cmd(FUNC_START, IdW'(i), 20'd1, 1'b0));
    end
    pending_cmds.push_back(mk_cmd(FUNC_START,  8'd9,   20'd1, 1'b0));
    // Restarting a present id on a full table still succeeds.
    pending_cmds.push_back(mk_cmd(FUNC_START,  8'd5,   20'hFFFFF, 1'b0));
    // Hold suppresses expiry; a query past the deadline answers zero.
    pending_cmds.push_back(mk_cmd(FUNC_HOLD,   8'd0,   20'd0, 1'b1));
    pending_cmds.push_back(mk_cmd(FUNC_TICK,   8'd0,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_SYNC,   8'd0,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_QUERY,  8'd1,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_HOLD,   8'd0,   20'd0, 1'b0));
    // Seven expiries on one tick, in start order.
    pending_cmds.push_back(mk_cmd(FUNC_TICK,   8'd0,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_QUERY,  8'd5,   20'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(FUNC_DELETE, 8'd5,   20'd0, 1'b0));
    // Unused codes are ignored.
    pending_cmds.push_back(mk_cmd(FUNC_UNUSED_LO, 8'd255, 20'hFFFFF, 1'b1));
    pending_cmds.push_back(mk_cmd(FUNC_UNUSED_HI, 8'd0,   20'd0,     1'b0));

    // Random part. Ids mostly come from a small pool and timeouts are mostly
    // short, so that restarts, hits, full tables and expiry bursts are common.
    useful = 0;
    while (useful < RandomCmds) begin
      r = $urandom_range(0, 99);
      if (r < 30)      c.func = FUNC_START;
      else if (r < 62) c.func = FUNC_TICK;
      else if (r < 70) c.func = FUNC_DELETE;
      else if (r < 82) c.func = FUNC_QUERY;
      else if (r < 88) c.func = FUNC_SYNC;
      else if (r < 95) c.func = FUNC_HOLD;
      else if (r < 97) c.func = ($urandom_range(0, 1) != 0) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
      else             c.func = FUNC_TICK;
      c.timer_id = ($urandom_range(0, 3) == 0) ? IdW'($urandom_range(0, 255))
                                                : IdW'($urandom_range(0, 11));
      r = $urandom_range(0, 99);
      if (r < 85)      c.timeout = TimeoutW'($urandom_range(0, 12));
      else if (r < 95) c.timeout = TimeoutW'($urandom_range(0, 300));
      else             c.timeout = TimeoutW'($urandom_range(0, (1 << TimeoutW) - 1));
      c.hold = ($urandom_range(0, 2) == 0);
      pending_cmds.push_back(c);
      if (c.func != FUNC_UNUSED_LO && c.func != FUNC_UNUSED_HI) useful++;
    end

    // Wait for every command to be taken and every result to arrive, then let
    // the block settle before the verdict.
    @(posedge rst_ni);
    while (pending_cmds.size() > 0 || drv_valid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
